### hw/rtl/uint_to_decimal_ascii_unit_assert.svh
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii_unit assertion macros
// property forms for the checker module
// ----------------------------------------------------------------------------
`ifndef UINT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define UINT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// same-cycle implication
`define U2DA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u2da assertion failed");

// next-cycle implication
`define U2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u2da assertion failed");

`endif

### hw/rtl/u2da_pkg.sv
// ----------------------------------------------------------------------------
// u2da_pkg
// types, constants and the power-of-ten tables for the decimal converter
// ----------------------------------------------------------------------------
package u2da_pkg;

  localparam int VALUE_W     = 32;
  localparam int DELIM_W     = 8;
  localparam int CHAR_W      = 8;
  localparam int IDX_W       = 4;
  localparam int DIGIT_W     = 4;
  localparam int POW_W       = 34;
  localparam int IN_DATA_W   = VALUE_W + DELIM_W;
  localparam int RADIX       = 10;
  localparam int MAX_IDX     = 9;
  localparam int MAX_DIGIT   = RADIX - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [DELIM_W-1:0] delimiter;
    logic [IDX_W-1:0]   top_idx;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EMIT,
    S_DELIM
  } back_state_t;

  // digit multiples of each power of ten, indexed [power][digit]
  typedef logic [MAX_IDX:0][MAX_DIGIT:0][POW_W-1:0] mult_tab_t;

  function automatic logic [POW_W-1:0] pow10(input logic [IDX_W-1:0] idx);
    logic [POW_W-1:0] p;
    unique case (idx)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd1;
    endcase
    return p;
  endfunction

  function automatic mult_tab_t build_mult_tab();
    mult_tab_t        t;
    logic [POW_W-1:0] p;
    p = POW_W'(1);
    for (int i = 0; i <= MAX_IDX; i++) begin
      for (int d = 0; d <= MAX_DIGIT; d++) begin
        t[i][d] = p * POW_W'(d);
      end
      p = p * POW_W'(RADIX);
    end
    return t;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

### hw/rtl/u2da_front.sv
// ----------------------------------------------------------------------------
// u2da_front
// input stage: takes items, finds the leading digit position, feeds the queue
// ----------------------------------------------------------------------------
module u2da_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // value [31:0], delimiter [39:32]
  input  logic [u2da_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                             push,
  output u2da_pkg::entry_t                 push_entry,
  input  u2da_pkg::q_status_t              q_status
);

  logic             fv;
  u2da_pkg::entry_t fentry;
  u2da_pkg::entry_t in_entry;
  logic [u2da_pkg::IDX_W-1:0] idx;

  always_comb begin
    idx = '0;
    for (int k = 1; k <= u2da_pkg::MAX_IDX; k++) begin
      if ({2'b00, s_tdata[u2da_pkg::VALUE_W-1:0]} >=
          u2da_pkg::pow10(u2da_pkg::IDX_W'(k))) begin
        idx = idx + 1'b1;
      end
    end
    in_entry.value     = s_tdata[u2da_pkg::VALUE_W-1:0];
    in_entry.delimiter = s_tdata[u2da_pkg::IN_DATA_W-1:u2da_pkg::VALUE_W];
    in_entry.top_idx   = idx;
  end

  assign push       = fv && !q_status.full;
  assign push_entry = fentry;
  assign s_tready   = !fv || !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fentry <= in_entry;
    end
  end

endmodule

### hw/rtl/u2da_queue.sv
// ----------------------------------------------------------------------------
// u2da_queue
// short queue between the input stage and the digit generator
// ----------------------------------------------------------------------------
module u2da_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u2da_pkg::entry_t    push_entry,
  input  logic                pop,
  output u2da_pkg::entry_t    head,
  output u2da_pkg::q_status_t q_status
);

  u2da_pkg::entry_t             mem [u2da_pkg::QUEUE_DEPTH];
  logic [u2da_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [u2da_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [u2da_pkg::QUEUE_CW-1:0] count;
  logic                          do_push;
  logic                          do_pop;

  assign q_status.full  = (count == u2da_pkg::QUEUE_CW'(u2da_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == u2da_pkg::QUEUE_AW'(u2da_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == u2da_pkg::QUEUE_AW'(u2da_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

### hw/rtl/u2da_back.sv
// ----------------------------------------------------------------------------
// u2da_back
// digit generator: each digit found by comparing the remainder with
// the multiples of the current power of ten, then emitted
// ----------------------------------------------------------------------------
module u2da_back (
  input  logic                          clk,
  input  logic                          rst,
  input  u2da_pkg::entry_t              head,
  input  u2da_pkg::q_status_t           q_status,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // char_code [7:0]
  output logic [u2da_pkg::CHAR_W-1:0]   m_tdata,
  output logic                          m_tlast
);

  u2da_pkg::back_state_t          state;
  u2da_pkg::back_state_t          state_next;
  logic [u2da_pkg::VALUE_W-1:0]   rem;
  logic [u2da_pkg::DELIM_W-1:0]   delim;
  logic [u2da_pkg::IDX_W-1:0]     pidx;
  logic [u2da_pkg::DIGIT_W-1:0]   digit;
  logic [u2da_pkg::DIGIT_W-1:0]   digit_calc;
  logic                           out_free;
  logic                           load_item;
  logic                           calc_en;
  logic                           load_digit;
  logic                           load_delim;
  logic [u2da_pkg::POW_W-1:0]     sub_val;

  assign out_free = !m_tvalid || m_tready;
  assign sub_val  = u2da_pkg::MULT_TAB[pidx][digit];

  // largest digit whose multiple still fits in the remainder
  always_comb begin
    digit_calc = '0;
    for (int k = 1; k <= u2da_pkg::MAX_DIGIT; k++) begin
      if ({2'b00, rem} >= u2da_pkg::MULT_TAB[pidx][k]) begin
        digit_calc = u2da_pkg::DIGIT_W'(k);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      u2da_pkg::S_IDLE: begin
        if (!q_status.empty) state_next = u2da_pkg::S_CALC;
      end
      u2da_pkg::S_CALC: begin
        state_next = u2da_pkg::S_EMIT;
      end
      u2da_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = (pidx == '0) ? u2da_pkg::S_DELIM : u2da_pkg::S_CALC;
        end
      end
      u2da_pkg::S_DELIM: begin
        if (out_free) state_next = u2da_pkg::S_IDLE;
      end
      default: state_next = u2da_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load_item  = 1'b0;
    calc_en    = 1'b0;
    load_digit = 1'b0;
    load_delim = 1'b0;
    unique case (state)
      u2da_pkg::S_IDLE:  load_item  = !q_status.empty;
      u2da_pkg::S_CALC:  calc_en    = 1'b1;
      u2da_pkg::S_EMIT:  load_digit = out_free;
      u2da_pkg::S_DELIM: load_delim = out_free;
      default: ;
    endcase
  end

  assign pop = load_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= u2da_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_digit || load_delim) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      rem   <= head.value;
      delim <= head.delimiter;
      pidx  <= head.top_idx;
    end else if (calc_en) begin
      digit <= digit_calc;
    end else if (load_digit) begin
      rem  <= rem - sub_val[u2da_pkg::VALUE_W-1:0];
      pidx <= pidx - 1'b1;
    end
    if (load_digit) begin
      m_tdata <= u2da_pkg::ASCII_ZERO + {4'b0000, digit};
      m_tlast <= 1'b0;
    end else if (load_delim) begin
      m_tdata <= delim;
      m_tlast <= 1'b1;
    end
  end

endmodule

### hw/rtl/uint_to_decimal_ascii_unit.sv
// path: an accepted item passes the input register, the queue, the back end's
//   idle, calc and emit states and the output register; output stalls delay it
// back end: calc then emit per digit, then the delimiter; one item at a time
// a two-entry queue and an input register let the input side run ahead
// reset: synchronous rst clears the queue, state machine and output valid
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii_unit
// converts a 32-bit unsigned value to ascii decimal followed by a delimiter
// ----------------------------------------------------------------------------
module uint_to_decimal_ascii_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // value [31:0], delimiter [39:32]
  input  logic [u2da_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // char_code [7:0]
  output logic [u2da_pkg::CHAR_W-1:0]    m_tdata,
  output logic                           m_tlast
);

  logic                push;
  logic                pop;
  u2da_pkg::entry_t    push_entry;
  u2da_pkg::entry_t    head;
  u2da_pkg::q_status_t q_status;

  u2da_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .q_status   (q_status)
  );

  u2da_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  u2da_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### hw/rtl/u2da_checker.sv
// ----------------------------------------------------------------------------
// u2da_checker
// port-level checks for the decimal converter, bound to the top level
// ----------------------------------------------------------------------------
`include "uint_to_decimal_ascii_unit_assert.svh"

module u2da_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [u2da_pkg::CHAR_W-1:0]    m_tdata,
  input logic                           m_tlast
);

  // stalled output holds
  `U2DA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // every character before the delimiter is an ascii digit
  `U2DA_ASSERT_IMPL(a_digit_range, clk, rst, m_tvalid && !m_tlast, (m_tdata >= 8'h30) && (m_tdata <= 8'h39))

  // right after reset nothing is shown and input is open
  `U2DA_ASSERT_IMPL(a_reset_clean, clk, rst, $past(rst), !m_tvalid && s_tready)

endmodule

bind uint_to_decimal_ascii_unit u2da_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
